// ===== hw/rtl/plt_pkg.sv =====
// Package for the punctuation/literal tokenizer.
// Holds token kinds, character codes, command and state types, and counter helpers.
// No dependencies.
package plt_pkg;

  localparam int MAX_LITERAL = 32;
  localparam int LEN_W = $clog2(MAX_LITERAL + 1);
  localparam int ADDR_W = (MAX_LITERAL > 1) ? $clog2(MAX_LITERAL) : 1;
  localparam int CNT_W = 16;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  localparam logic [2:0] KIND_LITERAL = 3'd0;
  localparam logic [2:0] KIND_LPAREN = 3'd1;
  localparam logic [2:0] KIND_RPAREN = 3'd2;
  localparam logic [2:0] KIND_COMMA = 3'd3;
  localparam logic [2:0] KIND_MINUS = 3'd4;
  localparam logic [2:0] KIND_COLON = 3'd5;
  localparam logic [2:0] KIND_DOT = 3'd6;
  localparam logic [2:0] KIND_END = 3'd7;

  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_DOT = 8'h2E;
  localparam logic [7:0] CH_NL = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_CR = 8'h0D;

  localparam logic MODE_END = 1'b1;

  typedef enum logic [2:0] {
    OP_LIT,
    OP_SPACE,
    OP_NL,
    OP_DOT,
    OP_PUNCT,
    OP_END
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] ch;
    logic [2:0] kind;
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FLUSH,
    ST_PUNCT
  } st_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    sat_inc = (v == CNT_MAX) ? v : v + 1'b1;
  endfunction

endpackage

// ===== hw/rtl/plt_front.sv =====
// Front end: accepts text items and classifies each into a back-end command.
// Depends on plt_pkg.
module plt_front import plt_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_ready,
  input  logic [7:0] char_code,
  input  logic       mode,
  output logic       cmd_valid,
  input  logic       cmd_ready,
  output cmd_t       cmd
);

  cmd_t cls;
  logic hold_valid;

  always_comb begin
    cls.ch = char_code;
    cls.kind = KIND_LITERAL;
    cls.op = OP_LIT;
    if (mode == MODE_END) begin
      cls.op = OP_END;
      cls.kind = KIND_END;
    end else begin
      case (char_code)
        CH_LPAREN: begin cls.op = OP_PUNCT; cls.kind = KIND_LPAREN; end
        CH_RPAREN: begin cls.op = OP_PUNCT; cls.kind = KIND_RPAREN; end
        CH_COMMA:  begin cls.op = OP_PUNCT; cls.kind = KIND_COMMA; end
        CH_MINUS:  begin cls.op = OP_PUNCT; cls.kind = KIND_MINUS; end
        CH_COLON:  begin cls.op = OP_PUNCT; cls.kind = KIND_COLON; end
        CH_DOT:    begin cls.op = OP_DOT; cls.kind = KIND_DOT; end
        CH_NL:     cls.op = OP_NL;
        default: begin
          if (char_code inside {CH_SPACE, CH_CR}) begin
            cls.op = OP_SPACE;
          end
        end
      endcase
    end
  end

  assign item_ready = !hold_valid || cmd_ready;
  assign cmd_valid = hold_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (item_ready) begin
      hold_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      cmd <= cls;
    end
  end

endmodule

// ===== hw/rtl/plt_queue.sv =====
// Two-entry command queue between the front end and the back end.
// Depends on plt_pkg.
module plt_queue import plt_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  cmd_t push_cmd,
  output logic pop_valid,
  input  logic pop_ready,
  output cmd_t pop_cmd
);

  cmd_t       entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid = (count != 2'd0);
  assign pop_cmd = entry[rd_ptr];
  assign push = push_valid && push_ready;
  assign pop = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_cmd;
    end
  end

endmodule

// ===== hw/rtl/plt_back.sv =====
// Back end: literal buffer, line/column counters, flush sequencer, output register.
// Depends on plt_pkg.
module plt_back import plt_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  output logic              cmd_ready,
  input  cmd_t              cmd,
  output logic              token_valid,
  input  logic              token_ready,
  output logic [2:0]        token_kind,
  output logic [7:0]        char_value,
  output logic [CNT_W-1:0]  token_line,
  output logic [CNT_W-1:0]  token_column,
  output logic              truncated,
  output logic              last_of_token,
  output logic              last
);

  logic [7:0]       mem [MAX_LITERAL];
  logic [7:0]       rd_data;

  st_t              state, state_next;
  logic [CNT_W-1:0] line, line_next;
  logic [CNT_W-1:0] col, col_next;
  logic [LEN_W-1:0] len, len_next;
  logic             ovf, ovf_next;
  logic [2:0]       pend_kind;
  logic             pend_nl;
  logic [CNT_W-1:0] flush_col;
  logic [LEN_W-1:0] rd_idx;
  logic [LEN_W-1:0] out_idx;
  logic             rd_pend;

  logic             can_load;
  logic             pop;
  logic             emit_lit;
  logic             last_lit;
  logic             rd_en;
  logic             wr_en;
  logic             emit_end;
  logic             emit_punct;
  logic [CNT_W-1:0] len_ext;
  logic [CNT_W-1:0] punct_col;

  assign can_load = !token_valid || token_ready;
  assign cmd_ready = (state == ST_IDLE) && (cmd.op != OP_END || can_load);
  assign pop = cmd_valid && cmd_ready;
  assign emit_end = pop && (cmd.op == OP_END);
  assign emit_lit = (state == ST_FLUSH) && rd_pend && can_load;
  assign last_lit = emit_lit && (out_idx == LEN_W'(len - 1'b1));
  assign rd_en = (state == ST_FLUSH) && (rd_idx < len) && (!rd_pend || emit_lit);
  assign emit_punct = (state == ST_PUNCT) && can_load;
  assign wr_en = pop && (cmd.op == OP_LIT) && (len < LEN_W'(MAX_LITERAL));
  assign len_ext = CNT_W'(len);
  assign punct_col = sat_inc((col >= len_ext) ? col - len_ext : '0);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (pop) begin
          if (cmd.op == OP_PUNCT || cmd.op == OP_DOT) begin
            state_next = (len == '0) ? ST_PUNCT : ST_FLUSH;
          end else if (cmd.op == OP_NL && len != '0) begin
            state_next = ST_FLUSH;
          end
        end
      end
      ST_FLUSH: begin
        if (last_lit) begin
          state_next = pend_nl ? ST_IDLE : ST_PUNCT;
        end
      end
      ST_PUNCT: begin
        if (can_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    line_next = line;
    col_next = col;
    len_next = len;
    ovf_next = ovf;
    if (pop) begin
      case (cmd.op)
        OP_LIT: begin
          if (len < LEN_W'(MAX_LITERAL)) begin
            len_next = len + 1'b1;
          end else begin
            ovf_next = 1'b1;
          end
          col_next = sat_inc(col);
        end
        OP_SPACE: col_next = sat_inc(col);
        OP_NL: begin
          if (len == '0) begin
            line_next = sat_inc(line);
            col_next = '0;
          end
        end
        OP_END: begin
          line_next = CNT_W'(1);
          col_next = '0;
          len_next = '0;
          ovf_next = 1'b0;
        end
        default: ;
      endcase
    end
    if (last_lit) begin
      len_next = '0;
      ovf_next = 1'b0;
      if (pend_nl) begin
        line_next = sat_inc(line);
        col_next = '0;
      end
    end
    if (emit_punct) begin
      col_next = sat_inc(col);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      line <= CNT_W'(1);
      col <= '0;
      len <= '0;
      ovf <= 1'b0;
      rd_pend <= 1'b0;
      rd_idx <= '0;
      out_idx <= '0;
      token_valid <= 1'b0;
    end else begin
      state <= state_next;
      line <= line_next;
      col <= col_next;
      len <= len_next;
      ovf <= ovf_next;
      if (pop) begin
        rd_pend <= 1'b0;
        rd_idx <= '0;
        out_idx <= '0;
      end else begin
        if (rd_en) begin
          rd_pend <= 1'b1;
          rd_idx <= rd_idx + 1'b1;
        end else if (emit_lit) begin
          rd_pend <= 1'b0;
        end
        if (emit_lit) begin
          out_idx <= out_idx + 1'b1;
        end
      end
      if (emit_end || emit_lit || emit_punct) begin
        token_valid <= 1'b1;
      end else if (token_ready) begin
        token_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[len[ADDR_W-1:0]] <= cmd.ch;
    end
    if (rd_en) begin
      rd_data <= mem[rd_idx[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      pend_kind <= cmd.kind;
      pend_nl <= (cmd.op == OP_NL);
      flush_col <= (cmd.op == OP_PUNCT) ? punct_col : col;
    end
    if (emit_end) begin
      token_kind <= KIND_END;
      char_value <= '0;
      token_line <= line;
      token_column <= col;
      truncated <= 1'b0;
      last_of_token <= 1'b1;
      last <= 1'b1;
    end else if (emit_lit) begin
      token_kind <= KIND_LITERAL;
      char_value <= rd_data;
      token_line <= line;
      token_column <= flush_col;
      truncated <= ovf;
      last_of_token <= last_lit;
      last <= last_lit && pend_nl;
    end else if (emit_punct) begin
      token_kind <= pend_kind;
      char_value <= '0;
      token_line <= line;
      token_column <= col;
      truncated <= 1'b0;
      last_of_token <= 1'b1;
      last <= 1'b1;
    end
  end

endmodule

// ===== hw/rtl/punctuation_literal_tokenizer.sv =====
// Top level of the punctuation/literal tokenizer: front end, command queue, back end.
// Depends on plt_pkg, plt_front, plt_queue, plt_back.
//
//   Channel  Handshake                  Payload
//   item     item_valid / item_ready    char_code, mode
//   token    token_valid / token_ready  token_kind, char_value, token_line,
//                                       token_column, truncated, last_of_token, last
//
// Ordinary bytes, space, CR and empty newlines are handled in the back end's idle state.
// A delimiter with a pending literal starts a flush: each buffered character is read from
// the buffer via a read register; the punctuation token then follows unless it is a newline.
// The back end handles one command at a time; a two-entry queue lets the front keep accepting.
// Reset is synchronous; line starts at 1, column at 0, buffer empty.
// A stalled token output holds flushes and token emission; the front stalls on a full queue.
module punctuation_literal_tokenizer import plt_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  logic [7:0]        char_code,
  input  logic              mode,
  output logic              token_valid,
  input  logic              token_ready,
  output logic [2:0]        token_kind,
  output logic [7:0]        char_value,
  output logic [CNT_W-1:0]  token_line,
  output logic [CNT_W-1:0]  token_column,
  output logic              truncated,
  output logic              last_of_token,
  output logic              last
);

  logic f_valid;
  logic f_ready;
  cmd_t f_cmd;
  logic q_valid;
  logic q_ready;
  cmd_t q_cmd;

  plt_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .char_code  (char_code),
    .mode       (mode),
    .cmd_valid  (f_valid),
    .cmd_ready  (f_ready),
    .cmd        (f_cmd)
  );

  plt_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_cmd   (f_cmd),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_cmd    (q_cmd)
  );

  plt_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cmd_valid     (q_valid),
    .cmd_ready     (q_ready),
    .cmd           (q_cmd),
    .token_valid   (token_valid),
    .token_ready   (token_ready),
    .token_kind    (token_kind),
    .char_value    (char_value),
    .token_line    (token_line),
    .token_column  (token_column),
    .truncated     (truncated),
    .last_of_token (last_of_token),
    .last          (last)
  );

endmodule
